// ----- rtl/core/nsc_pkg.sv -----
package nsc_pkg;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_START = 3'd1,
		ST_NO_STAR   = 3'd2,
		ST_BAD_HEX   = 3'd3,
		ST_MISMATCH  = 3'd4,
		ST_ADDR_LEN  = 3'd5
	} nsc_status_t;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;

	localparam int unsigned ADDR_LEN   = 5;
	localparam int unsigned FIELDS_W   = 6;
	localparam int unsigned TDATA_IN_W  = 8;
	localparam int unsigned TDATA_OUT_W = 56;

	// sentence summary after the current item has been folded in
	typedef struct packed {
		logic                start_ok;
		logic                star_seen;
		logic [1:0]          chars_after_star;
		logic [15:0]         tail_chars;
		logic [7:0]          xor_at_star;
		logic [2:0]          address_length_at_star;
		logic [39:0]         address_chars;
		logic [FIELDS_W-1:0] fields_at_star;
	} nsc_summary_t;

endpackage

// ----- rtl/core/nsc_track.sv -----
module nsc_track
	import nsc_pkg::*;
#(
	parameter int unsigned FIELD_COUNT_MAX = 63
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         fire,
	input  logic [7:0]   char_in,
	input  logic         last_char,
	output nsc_summary_t summary
);

	localparam int unsigned CW = $clog2(FIELD_COUNT_MAX + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(FIELD_COUNT_MAX);

	logic          started_q, start_ok_q, comma_seen_q, star_seen_q;
	logic [7:0]    running_xor_q, xor_at_star_q;
	logic [1:0]    pend_q, chars_after_q;
	logic [2:0]    alen_q, alen_at_star_q;
	logic [CW-1:0] comma_count_q, fields_at_star_q;
	logic [39:0]   addr_q;
	logic [15:0]   tail_q;

	logic          started_d, start_ok_d, comma_seen_d, star_seen_d;
	logic [7:0]    running_xor_d, xor_at_star_d;
	logic [1:0]    pend_d, chars_after_d;
	logic [2:0]    alen_d, alen_at_star_d;
	logic [CW-1:0] comma_count_d, fields_at_star_d;
	logic [39:0]   addr_d;
	logic [15:0]   tail_d;
	logic          is_crlf;
	logic [2:0]    chars_sum;

	assign is_crlf = (char_in == CH_CR) || (char_in == CH_LF);

	always_comb begin
		started_d        = started_q;
		start_ok_d       = start_ok_q;
		comma_seen_d     = comma_seen_q;
		star_seen_d      = star_seen_q;
		running_xor_d    = running_xor_q;
		xor_at_star_d    = xor_at_star_q;
		pend_d           = pend_q;
		chars_after_d    = chars_after_q;
		alen_d           = alen_q;
		alen_at_star_d   = alen_at_star_q;
		comma_count_d    = comma_count_q;
		fields_at_star_d = fields_at_star_q;
		addr_d           = addr_q;
		tail_d           = tail_q;
		chars_sum        = 3'd0;
		if (!started_q) begin
			started_d  = 1'b1;
			start_ok_d = (char_in == CH_DOLLAR) || (char_in == CH_BANG);
		end else if (is_crlf) begin
			if (pend_q != 2'd3) begin
				pend_d = pend_q + 2'd1;
			end
			running_xor_d = running_xor_q ^ char_in;
			if (!comma_seen_q) begin
				if (alen_q < 3'(ADDR_LEN)) begin
					addr_d = {addr_q[31:0], char_in};
				end
				if (alen_q < 3'(ADDR_LEN + 1)) begin
					alen_d = alen_q + 3'd1;
				end
			end
		end else begin
			// held-back cr/lf run replays as cr bytes after the star
			if (star_seen_q) begin
				chars_sum     = {1'b0, chars_after_q} + {1'b0, pend_q};
				chars_after_d = (chars_sum > 3'd3) ? 2'd3 : chars_sum[1:0];
				if (pend_q == 2'd1) begin
					tail_d = {tail_q[7:0], CH_CR};
				end else if (pend_q != 2'd0) begin
					tail_d = {CH_CR, CH_CR};
				end
			end
			pend_d = 2'd0;
			if (char_in == CH_STAR) begin
				star_seen_d      = 1'b1;
				xor_at_star_d    = running_xor_q;
				alen_at_star_d   = alen_q;
				fields_at_star_d = comma_count_q;
				chars_after_d    = 2'd0;
				tail_d           = 16'd0;
			end else if (star_seen_q) begin
				if (chars_after_d != 2'd3) begin
					chars_after_d = chars_after_d + 2'd1;
				end
				tail_d = {tail_d[7:0], char_in};
			end
			running_xor_d = running_xor_q ^ char_in;
			if (char_in == CH_COMMA) begin
				comma_seen_d = 1'b1;
				if (comma_count_q < CNT_MAX) begin
					comma_count_d = comma_count_q + CW'(1);
				end
			end else if (!comma_seen_q) begin
				if (alen_q < 3'(ADDR_LEN)) begin
					addr_d = {addr_q[31:0], char_in};
				end
				if (alen_q < 3'(ADDR_LEN + 1)) begin
					alen_d = alen_q + 3'd1;
				end
			end
		end
	end

	always_comb begin
		summary.start_ok               = start_ok_d;
		summary.star_seen              = star_seen_d;
		summary.chars_after_star       = chars_after_d;
		summary.tail_chars             = tail_d;
		summary.xor_at_star            = xor_at_star_d;
		summary.address_length_at_star = alen_at_star_d;
		summary.address_chars          = addr_d;
		summary.fields_at_star         = FIELDS_W'(fields_at_star_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q        <= 1'b0;
			start_ok_q       <= 1'b0;
			comma_seen_q     <= 1'b0;
			star_seen_q      <= 1'b0;
			running_xor_q    <= 8'd0;
			xor_at_star_q    <= 8'd0;
			pend_q           <= 2'd0;
			chars_after_q    <= 2'd0;
			alen_q           <= 3'd0;
			alen_at_star_q   <= 3'd0;
			comma_count_q    <= '0;
			fields_at_star_q <= '0;
			addr_q           <= 40'd0;
			tail_q           <= 16'd0;
		end else if (fire) begin
			if (last_char) begin
				started_q        <= 1'b0;
				start_ok_q       <= 1'b0;
				comma_seen_q     <= 1'b0;
				star_seen_q      <= 1'b0;
				running_xor_q    <= 8'd0;
				xor_at_star_q    <= 8'd0;
				pend_q           <= 2'd0;
				chars_after_q    <= 2'd0;
				alen_q           <= 3'd0;
				alen_at_star_q   <= 3'd0;
				comma_count_q    <= '0;
				fields_at_star_q <= '0;
				addr_q           <= 40'd0;
				tail_q           <= 16'd0;
			end else begin
				started_q        <= started_d;
				start_ok_q       <= start_ok_d;
				comma_seen_q     <= comma_seen_d;
				star_seen_q      <= star_seen_d;
				running_xor_q    <= running_xor_d;
				xor_at_star_q    <= xor_at_star_d;
				pend_q           <= pend_d;
				chars_after_q    <= chars_after_d;
				alen_q           <= alen_d;
				alen_at_star_q   <= alen_at_star_d;
				comma_count_q    <= comma_count_d;
				fields_at_star_q <= fields_at_star_d;
				addr_q           <= addr_d;
				tail_q           <= tail_d;
			end
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_char |=> !started_q && !star_seen_q && pend_q == 2'd0)
		else $error("sentence state not cleared after last item");
	a_tail_needs_star: assert property (@(posedge clk) disable iff (!arst_n)
		!star_seen_q |-> chars_after_q == 2'd0 && tail_q == 16'd0)
		else $error("characters after star counted without a star");
	a_pend_needs_start: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd0 |-> started_q)
		else $error("cr/lf run pending before start character");

endmodule

// ----- rtl/core/nsc_verdict.sv -----
module nsc_verdict
	import nsc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  nsc_summary_t        summary,
	input  logic                ready,
	output logic                out_free,
	output logic                valid,
	output logic [2:0]          status,
	output logic [15:0]         talker,
	output logic [23:0]         message_type,
	output logic [FIELDS_W-1:0] data_field_count
);

	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		// bit 4 set marks a byte that is not a hex digit
		logic [4:0] r;
		r = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b0, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b0, 4'(c - 8'h57)};
		end
		return r;
	endfunction

	logic                valid_q;
	logic [2:0]          status_q;
	logic [15:0]         talker_q;
	logic [23:0]         mtype_q;
	logic [FIELDS_W-1:0] fields_q;
	logic [4:0]          hi, lo;
	nsc_status_t         st;

	assign hi = hex_digit(summary.tail_chars[15:8]);
	assign lo = hex_digit(summary.tail_chars[7:0]);

	always_comb begin
		if (!summary.start_ok) begin
			st = ST_BAD_START;
		end else if (!summary.star_seen || summary.chars_after_star != 2'd2) begin
			st = ST_NO_STAR;
		end else if (hi[4] || lo[4]) begin
			st = ST_BAD_HEX;
		end else if (summary.xor_at_star != {hi[3:0], lo[3:0]}) begin
			st = ST_MISMATCH;
		end else if (summary.address_length_at_star != 3'(ADDR_LEN)) begin
			st = ST_ADDR_LEN;
		end else begin
			st = ST_OK;
		end
	end

	assign out_free = !valid_q || ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && out_free) begin
			status_q <= st;
			if (st == ST_OK) begin
				talker_q <= summary.address_chars[39:24];
				mtype_q  <= summary.address_chars[23:0];
				fields_q <= summary.fields_at_star;
			end else begin
				talker_q <= 16'd0;
				mtype_q  <= 24'd0;
				fields_q <= '0;
			end
		end
	end

	assign valid            = valid_q;
	assign status           = status_q;
	assign talker           = talker_q;
	assign message_type     = mtype_q;
	assign data_field_count = fields_q;

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load && out_free |=> valid_q)
		else $error("loaded result not presented");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !ready |=> valid_q && $stable(status_q) && $stable(talker_q))
		else $error("waiting result lost");
	a_zero_unless_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && status_q != ST_OK |-> talker_q == 16'd0 && mtype_q == 24'd0
			&& fields_q == '0)
		else $error("fields not zero on failed sentence");

endmodule

// ----- rtl/core/nmea_sentence_checker_unit.sv -----
// a last item passes the input register; results wait in a single output register
// throughput: one item per cycle unless a stalled result holds back a last item
// only an item flagged last makes a result; other items make none
// a stalled result blocks only a last item in the input register
// reset: arst_n asynchronous active low; clears both valid flags and the sentence state
module nmea_sentence_checker_unit
	import nsc_pkg::*;
#(
	parameter int unsigned FIELD_COUNT_MAX = 63
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [TDATA_IN_W-1:0]  s_axis_tdata,  // char_in
	input  logic                   s_axis_tlast,  // last_char
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// status, talker, message_type, data_field_count, zero fill
	output logic [TDATA_OUT_W-1:0] m_axis_tdata
);

	logic                valid_s1, last_s1;
	logic [7:0]          char_s1;
	logic                fire, out_free;
	nsc_summary_t        summary;
	logic [2:0]          status;
	logic [15:0]         talker;
	logic [23:0]         message_type;
	logic [FIELDS_W-1:0] data_field_count;

	assign fire          = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata[7:0];
			last_s1 <= s_axis_tlast;
		end
	end

	nsc_track #(
		.FIELD_COUNT_MAX(FIELD_COUNT_MAX)
	) u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.char_in  (char_s1),
		.last_char(last_s1),
		.summary  (summary)
	);

	nsc_verdict u_verdict (
		.clk             (clk),
		.arst_n          (arst_n),
		.load            (fire && last_s1),
		.summary         (summary),
		.ready           (m_axis_tready),
		.out_free        (out_free),
		.valid           (m_axis_tvalid),
		.status          (status),
		.talker          (talker),
		.message_type    (message_type),
		.data_field_count(data_field_count)
	);

	assign m_axis_tdata = {7'd0, data_field_count, message_type, talker, status};

endmodule
